### hdl/n2w_pkg.sv
// Shared types, token codes and the group-to-slot function for the number-to-word unit.
// Depends on nothing; every other file in hdl imports it.
`timescale 1ns / 1ps
`default_nettype none

package n2w_pkg;

    localparam int VALUE_W    = 31;
    localparam int WORD_W     = 5;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int NUM_SLOTS  = 16;
    localparam int GRP_SLOTS  = 5;
    localparam int GAP_W      = $clog2(NUM_SLOTS);

    localparam logic [WORD_W-1:0] WORD_ZERO      = 5'd0;
    localparam logic [WORD_W-1:0] WORD_TEN       = 5'd10;
    localparam logic [WORD_W-1:0] WORD_TENS_BASE = 5'd18;
    localparam logic [WORD_W-1:0] WORD_HUNDRED   = 5'd28;
    localparam logic [WORD_W-1:0] WORD_THOUSAND  = 5'd29;
    localparam logic [WORD_W-1:0] WORD_MILLION   = 5'd30;
    localparam logic [WORD_W-1:0] WORD_BILLION   = 5'd31;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word;
        logic              last;
    } t_tok;

    typedef t_tok [GRP_SLOTS-1:0] t_grp;

    typedef struct packed {
        logic               valid;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } t_dd;

    // Slots of one three-digit group: hundreds digit, Hundred, tens word,
    // ones or teen word, scale word. The last flag is filled in later.
    function automatic t_grp f_group(input logic [3:0] h, input logic [3:0] t,
                                     input logic [3:0] o, input logic [WORD_W-1:0] scale,
                                     input logic has_scale);
        t_grp g;
        g = '0;
        g[0].valid = (h != 4'd0);
        g[0].word  = {1'b0, h};
        g[1].valid = (h != 4'd0);
        g[1].word  = WORD_HUNDRED;
        g[2].valid = (t >= 4'd2);
        g[2].word  = WORD_TENS_BASE + {1'b0, t};
        if (t == 4'd1) begin
            g[3].valid = 1'b1;
            g[3].word  = WORD_TEN + {1'b0, o};
        end else begin
            g[3].valid = (o != 4'd0);
            g[3].word  = {1'b0, o};
        end
        g[4].valid = has_scale && ((h != 4'd0) || (t != 4'd0) || (o != 4'd0));
        g[4].word  = scale;
        return g;
    endfunction

endpackage

`default_nettype wire

### hdl/n2w_dd_cell.sv
// One shift-and-add-3 step of the binary to decimal conversion chain.
// Depends on n2w_pkg for the stage type and widths.
`timescale 1ns / 1ps
`default_nettype none

module n2w_dd_cell
    import n2w_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_dd  i_stage,
    output t_dd       o_stage
);

    logic [BCD_W-1:0] adj;
    t_dd              n_stage;
    t_dd              r_stage;

    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (i_stage.bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = i_stage.bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = i_stage.bcd[4*k +: 4];
            end
        end
        n_stage       = i_stage;
        n_stage.bcd   = {adj[BCD_W-2:0], i_stage.bin[VALUE_W-1]};
        n_stage.bin   = {i_stage.bin[VALUE_W-2:0], 1'b0};
    end

    // Only the valid bit is reset; the data simply follows it down the chain.
    always_ff @(posedge i_clk) begin
        r_stage.bcd <= n_stage.bcd;
        r_stage.bin <= n_stage.bin;
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

### hdl/n2w_tok_cell.sv
// One slot of the token output chain: loads in parallel or takes its neighbor's token.
// Depends on n2w_pkg for the token type.
`timescale 1ns / 1ps
`default_nettype none

module n2w_tok_cell
    import n2w_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_load,
    input  wire t_tok i_load_tok,
    input  wire t_tok i_next_tok,
    output t_tok      o_tok
);

    t_tok n_tok;
    t_tok r_tok;

    assign n_tok = i_load ? i_load_tok : i_next_tok;

    always_ff @(posedge i_clk) begin
        r_tok.word <= n_tok.word;
        r_tok.last <= n_tok.last;
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

### hdl/number_to_word_tokens_unit.sv
// Top level of the number-to-word unit: decimal conversion chain and token chain.
// Depends on n2w_pkg, n2w_dd_cell and n2w_tok_cell.
//
// Usage:
//   A request is accepted at a rising edge where start is high and busy is low;
//   i_value carries a 31-bit unsigned number. Its English spelling leaves as a
//   run of word tokens on o_word, each shown for exactly one cycle with o_strobe
//   high; o_last_word marks the final token of the number.
//   The number first walks a chain of 31 conversion cells, one input bit per
//   cell, that turns it into ten decimal digits. The digits then fill a chain of
//   16 token slots (Billion digit, Billion, five slots each for the
//   million and thousand groups, four for the units), which shifts one slot
//   toward the output every cycle. Empty slots give cycles without a strobe.
//   A request passes through the conversion cells and is then loaded into the
//   token chain, whose slots reach the outputs in slot order, Billion digit first.
//   Requests are spaced by the length of the token chain: busy stays high after
//   each accepted request until the gap counter, loaded with the slot count
//   less one, runs down to zero, and a new request is taken while the previous
//   one is still emitting.
//   The receiver cannot stall; tokens are never held back.
//   Reset (synchronous, active low) drops every request in flight.
`timescale 1ns / 1ps
`default_nettype none

module number_to_word_tokens_unit
    import n2w_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire logic [VALUE_W-1:0] i_value,
    output      logic [WORD_W-1:0]  o_word,
    output      logic               o_last_word,
    output      logic               o_strobe
);

    logic             accept;
    logic [GAP_W-1:0] r_gap_cnt;
    logic [GAP_W-1:0] n_gap_cnt;

    t_dd              dd_chain [0:VALUE_W];
    t_dd              dd_out;
    logic [3:0]       dig [0:NUM_DIGITS-1];
    t_grp             grp_m;
    t_grp             grp_t;
    t_grp             grp_u;
    t_tok             slot [0:NUM_SLOTS-1];
    logic [NUM_SLOTS-1:0] slot_vld;
    logic [NUM_SLOTS-1:0] slot_last;
    t_tok             tok_q [0:NUM_SLOTS];
    logic [NUM_SLOTS-1:0] chain_vld;

    // Requests are spaced by the length of the token chain, so a load always
    // finds the chain drained.
    assign accept = start && !busy;
    assign busy   = (r_gap_cnt != '0);

    always_comb begin
        n_gap_cnt = r_gap_cnt;
        if (accept) begin
            n_gap_cnt = GAP_W'(NUM_SLOTS - 1);
        end else if (r_gap_cnt != '0) begin
            n_gap_cnt = r_gap_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_cnt <= '0;
        end else begin
            r_gap_cnt <= n_gap_cnt;
        end
    end

    assign dd_chain[0] = '{valid: accept, bcd: '0, bin: i_value};

    for (genvar k = 0; k < VALUE_W; k++) begin : g_dd
        n2w_dd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (dd_chain[k]),
            .o_stage (dd_chain[k+1])
        );
    end

    assign dd_out = dd_chain[VALUE_W];

    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            dig[k] = dd_out.bcd[4*k +: 4];
        end
    end

    assign grp_m = f_group(dig[8], dig[7], dig[6], WORD_MILLION, 1'b1);
    assign grp_t = f_group(dig[5], dig[4], dig[3], WORD_THOUSAND, 1'b1);
    assign grp_u = f_group(dig[2], dig[1], dig[0], WORD_ZERO, 1'b0);

    always_comb begin
        slot[0] = '{valid: (dig[9] != 4'd0), word: {1'b0, dig[9]}, last: 1'b0};
        slot[1] = '{valid: (dig[9] != 4'd0), word: WORD_BILLION, last: 1'b0};
        for (int k = 0; k < GRP_SLOTS; k++) begin
            slot[2 + k] = grp_m[k];
            slot[2 + GRP_SLOTS + k] = grp_t[k];
        end
        for (int k = 0; k < GRP_SLOTS - 1; k++) begin
            slot[2 + 2*GRP_SLOTS + k] = grp_u[k];
        end
        // A value of zero spells as the single word Zero in the units slot.
        if (dd_out.bcd == '0) begin
            slot[NUM_SLOTS-1].valid = 1'b1;
            slot[NUM_SLOTS-1].word  = WORD_ZERO;
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_vld[k] = slot[k].valid;
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
            slot_last[k] = slot_vld[k] && ((slot_vld >> (k + 1)) == '0);
            slot[k].last = slot_last[k];
        end
    end

    assign tok_q[NUM_SLOTS] = '0;

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_tok
        n2w_tok_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (dd_out.valid),
            .i_load_tok (slot[k]),
            .i_next_tok (tok_q[k+1]),
            .o_tok      (tok_q[k])
        );
        assign chain_vld[k] = tok_q[k].valid;
    end

    assign o_strobe    = tok_q[0].valid;
    assign o_word      = tok_q[0].word;
    assign o_last_word = tok_q[0].valid && tok_q[0].last;

    // Checks.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted request");

    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dd_out.valid |-> ($countones(chain_vld[NUM_SLOTS-1:1]) == 0))
        else $error("token chain still holds tokens at load");

    a_one_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dd_out.valid |-> $onehot(slot_last))
        else $error("loaded frame lacks exactly one final token");

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_word |-> o_strobe)
        else $error("final token flag without strobe");

endmodule

`default_nettype wire

### sim/n2w_token_checker.sv
// Checker for the number-to-word unit: watches requests and word tokens, predicts the
// spelling of each accepted number and compares every token in order.
// Depends on n2w_pkg for widths and token codes.
`timescale 1ns / 1ps

module n2w_token_checker
    import n2w_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [WORD_W-1:0]  o_word,
    input  wire logic               o_last_word,
    input  wire logic               o_strobe,
    output int                      fail_count,
    output int                      tokens_left,
    output int                      numbers_taken,
    output int                      tokens_checked,
    output int                      long_numbers
);

    localparam logic [WORD_W-1:0] TOK_TWENTY = 5'd20;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_spoken;

    t_spoken           expected_words[$];
    logic [WORD_W-1:0] spelled[$];

    task automatic report(input string what);
        fail_count++;
        if (fail_count <= 30) begin
            $display("[%0t] %s", $time, what);
        end
    endtask

    // Words of one three-digit group, followed by its scale word if it has one.
    function automatic void add_group(input int unsigned g, input logic [WORD_W-1:0] scale_word,
                                      input bit scaled);
        int unsigned hund;
        int unsigned rest;
        hund = g / 100;
        rest = g % 100;
        if (g == 0) begin
            return;
        end
        if (hund != 0) begin
            spelled.push_back(WORD_W'(hund));
            spelled.push_back(WORD_HUNDRED);
        end
        if (rest >= 20) begin
            spelled.push_back(TOK_TWENTY + WORD_W'(rest / 10 - 2));
            rest = rest % 10;
        end
        if (rest != 0) begin
            spelled.push_back(WORD_W'(rest));
        end
        if (scaled) begin
            spelled.push_back(scale_word);
        end
    endfunction

    function automatic void spell_value(input logic [VALUE_W-1:0] v);
        int unsigned n;
        t_spoken     tok;
        n = 32'(v);
        spelled.delete();
        if (n == 0) begin
            spelled.push_back(WORD_ZERO);
        end else begin
            add_group(n / 1000000000, WORD_BILLION, 1'b1);
            add_group((n / 1000000) % 1000, WORD_MILLION, 1'b1);
            add_group((n / 1000) % 1000, WORD_THOUSAND, 1'b1);
            add_group(n % 1000, WORD_ZERO, 1'b0);
        end
        foreach (spelled[i]) begin
            tok.word = spelled[i];
            tok.last = (i == spelled.size() - 1);
            expected_words.push_back(tok);
        end
        if (spelled.size() == 16) begin
            long_numbers++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_spoken want;
        if (!i_rst_n) begin
            expected_words.delete();
        end else begin
            if ($isunknown(o_strobe)) begin
                report("token strobe is unknown");
            end else if (o_strobe) begin
                if (expected_words.size() == 0) begin
                    report($sformatf("token %0d arrived with no number waiting", o_word));
                end else begin
                    want = expected_words.pop_front();
                    tokens_checked++;
                    if (o_word !== want.word) begin
                        report($sformatf("word token %0d, expected %0d", o_word, want.word));
                    end
                    if (o_last_word !== want.last) begin
                        report($sformatf("last-word flag %b on token %0d, expected %b",
                                         o_last_word, o_word, want.last));
                    end
                end
            end
            if (start && !busy) begin
                numbers_taken++;
                spell_value(i_value);
            end
        end
        tokens_left = expected_words.size();
    end

endmodule

### sim/tb.sv
// Testbench top for number_to_word_tokens_unit: clock, reset and request stimulus.
// Depends on n2w_pkg, the unit itself and n2w_token_checker, which does all checking.
`timescale 1ns / 1ps

module tb;
    import n2w_pkg::*;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               busy;
    logic [WORD_W-1:0]  o_word;
    logic               o_last_word;
    logic               o_strobe;

    int fail_count;
    int tokens_left;
    int numbers_taken;
    int tokens_checked;
    int long_numbers;

    // Extremes, every teen, every tens word, every scale word and a sixteen-token number.
    logic [VALUE_W-1:0] directed_values [0:24] = '{
        0, 1, 9, 10, 13, 19, 20, 21, 99, 100, 101, 115, 999, 1000, 1000000,
        1000000000, 1001001001, 1777777777, 2147483647, 2000000000, 1585858858,
        11012014, 15016017, 1018000000, 1330660000
    };

    always #5 i_clk = ~i_clk;

    number_to_word_tokens_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_word      (o_word),
        .o_last_word (o_last_word),
        .o_strobe    (o_strobe)
    );

    n2w_token_checker token_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .o_word         (o_word),
        .o_last_word    (o_last_word),
        .o_strobe       (o_strobe),
        .fail_count     (fail_count),
        .tokens_left    (tokens_left),
        .numbers_taken  (numbers_taken),
        .tokens_checked (tokens_checked),
        .long_numbers   (long_numbers)
    );

    // Called at a rising edge; returns at the rising edge that accepts the request.
    task automatic send_value(input logic [VALUE_W-1:0] v, input bit may_idle);
        bit was_free;
        if (may_idle && $urandom_range(99) < 33) begin
            repeat ($urandom_range(1, 40)) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start   <= 1'b1;
        i_value <= v;
        do begin
            @(negedge i_clk);
            was_free = !busy;
            @(posedge i_clk);
        end while (!was_free);
    endtask

    // Called at a rising edge with start already lowered; returns at a rising edge.
    task automatic wait_for_silence(input int limit);
        int waited;
        waited = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while (tokens_left != 0 && waited < limit);
        @(posedge i_clk);
    endtask

    initial begin
        logic [VALUE_W-1:0] v;
        longint unsigned    acc;
        int unsigned        grp;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[i]) begin
            send_value(directed_values[i], 1'b1);
        end
        start <= 1'b0;
        wait_for_silence(2000);

        for (int n = 0; n < 450; n++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: v = VALUE_W'($urandom);
                4, 5, 6: begin
                    // Groups shaped toward zeros, teens, round tens and full spellings.
                    acc = 64'($urandom_range(0, 2));
                    for (int k = 0; k < 3; k++) begin
                        case ($urandom_range(5))
                            0: grp = 0;
                            1: grp = $urandom_range(1, 19);
                            2: grp = 10 * $urandom_range(2, 9);
                            3: grp = 100 * $urandom_range(1, 9) + $urandom_range(10, 19);
                            4: grp = 100 * $urandom_range(1, 9) + 10 * $urandom_range(2, 9)
                                     + $urandom_range(1, 9);
                            default: grp = $urandom_range(0, 999);
                        endcase
                        acc = acc * 1000 + grp;
                    end
                    if (acc > 64'd2147483647) begin
                        acc = acc - 64'd1000000000;
                    end
                    v = acc[VALUE_W-1:0];
                end
                7: v = $urandom_range(0, 1100);
                8: v = 31'h7FFF_FFFF - $urandom_range(0, 2000);
                default: begin
                    // Every group spelled with all of its words: sixteen tokens.
                    acc = 1;
                    for (int k = 0; k < 3; k++) begin
                        acc = acc * 1000 + 100 * $urandom_range(1, 9)
                              + 10 * $urandom_range(2, 9) + $urandom_range(1, 9);
                    end
                    v = acc[VALUE_W-1:0];
                end
            endcase
            send_value(v, !(n >= 150 && n < 280));
            if (n == 320) begin
                start <= 1'b0;
                wait_for_silence(2000);
            end
        end
        start <= 1'b0;
        wait_for_silence(2000);
        repeat (50) @(posedge i_clk);

        $display("Spelled %0d numbers into %0d compared word tokens; %0d numbers took sixteen.",
                 numbers_taken, tokens_checked, long_numbers);
        if (tokens_left != 0) begin
            $display("%0d expected word tokens never came out", tokens_left);
        end
        if (fail_count == 0 && tokens_left == 0) begin
            $display("number_to_word_tokens_unit: match");
        end else begin
            $display("number_to_word_tokens_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run did not finish in time");
        $display("number_to_word_tokens_unit: mismatch");
        $finish;
    end

endmodule
